// ----- src/q_learning_table_update_top_assert.svh -----
// Assertion macros for the Q-table update block.
// Included by the top module, which carries the concurrent checks; no other dependencies.
`ifndef Q_LEARNING_TABLE_UPDATE_TOP_ASSERT_SVH
`define Q_LEARNING_TABLE_UPDATE_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Check a property on every rising edge outside reset
`define QLTU_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("qltu: property violated");
// Check that a condition never holds outside reset
`define QLTU_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("qltu: forbidden condition seen");
`else
`define QLTU_ASSERT(lbl, clk, rstn, prop)
`define QLTU_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ----- src/qltu_pkg.sv -----
// Shared types and constants of the Q-table update block.
// No dependencies; imported by every module of the block.
package qltu_pkg;

  // Fixed field widths
  localparam int STATE_W  = 8;
  localparam int ACT_W    = 3;
  localparam int EPOCH_W  = 20;
  localparam int DRAW_W   = 7;
  localparam int Q_W      = 32;
  localparam int LR_W     = 17;
  localparam int SCALE_W  = 24;
  localparam int FLOOR_W  = 7;
  localparam int STATE_SPAN = 1 << STATE_W;

  // APB register file
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;
  localparam logic [2:0] REG_LEARNING_RATE = 3'd0;
  localparam logic [2:0] REG_DISCOUNT      = 3'd1;
  localparam logic [2:0] REG_EXPLORE_SCALE = 3'd2;
  localparam logic [2:0] REG_EXPLORE_FLOOR = 3'd3;
  localparam logic [2:0] REG_GREEDY_ONLY   = 3'd4;

  localparam logic [LR_W-1:0]    LR_RESET    = 17'd6554;
  localparam logic [LR_W-1:0]    DISC_RESET  = 17'd39322;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd12500;
  localparam logic [FLOOR_W-1:0] FLOOR_RESET = 7'd10;

  // Request kinds
  localparam logic REQ_CHOOSE = 1'b0;
  localparam logic REQ_UPDATE = 1'b1;

  // Cycles from start to done of the update arithmetic
  localparam int ALU_LAT = 6;

  typedef struct packed {
    logic                      req_type;
    logic [STATE_W-1:0]        cur_state;
    logic [EPOCH_W-1:0]        epoch;
    logic [DRAW_W-1:0]         random_draw;
    logic [ACT_W-1:0]          random_action;
    logic [ACT_W-1:0]          taken_action;
    logic signed [Q_W-1:0]     reward;
    logic [STATE_W-1:0]        next_state;
  } qltu_in_t;

  typedef struct packed {
    logic [ACT_W-1:0]          chosen_action;
    logic                      explored;
    logic signed [Q_W-1:0]     new_value;
  } qltu_out_t;

  typedef struct packed {
    logic [LR_W-1:0]    learning_rate;
    logic [LR_W-1:0]    discount;
    logic [SCALE_W-1:0] explore_scale;
    logic [FLOOR_W-1:0] explore_floor_percent;
    logic               greedy_only;
  } qltu_cfg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHK,
    ST_SCAN,
    ST_SDRAIN,
    ST_OLDW,
    ST_ALU,
    ST_WR,
    ST_FIN
  } qltu_state_t;

endpackage

// ----- src/qltu_cfg_regs.sv -----
// APB register file of the Q-table update block.
// Depends on qltu_pkg for register codes, reset values and the config struct.
module qltu_cfg_regs
  import qltu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output qltu_cfg_t         cfg
);

  qltu_cfg_t   cfg_r;
  logic        wr_hit;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_AW-1:2];
  assign wr_hit  = psel && penable && pwrite && pready;
  assign cfg     = cfg_r;

  // Write registers on the access phase; ignore unmapped addresses
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.learning_rate         <= LR_RESET;
      cfg_r.discount              <= DISC_RESET;
      cfg_r.explore_scale         <= SCALE_RESET;
      cfg_r.explore_floor_percent <= FLOOR_RESET;
      cfg_r.greedy_only           <= 1'b0;
    end else if (wr_hit) begin
      unique case (reg_idx)
        REG_LEARNING_RATE: cfg_r.learning_rate         <= pwdata[LR_W-1:0];
        REG_DISCOUNT:      cfg_r.discount              <= pwdata[LR_W-1:0];
        REG_EXPLORE_SCALE: cfg_r.explore_scale         <= pwdata[SCALE_W-1:0];
        REG_EXPLORE_FLOOR: cfg_r.explore_floor_percent <= pwdata[FLOOR_W-1:0];
        REG_GREEDY_ONLY:   cfg_r.greedy_only           <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Return the addressed register, zero elsewhere
  always_comb begin
    unique case (reg_idx)
      REG_LEARNING_RATE: prdata = CFG_DW'(cfg_r.learning_rate);
      REG_DISCOUNT:      prdata = CFG_DW'(cfg_r.discount);
      REG_EXPLORE_SCALE: prdata = CFG_DW'(cfg_r.explore_scale);
      REG_EXPLORE_FLOOR: prdata = CFG_DW'(cfg_r.explore_floor_percent);
      REG_GREEDY_ONLY:   prdata = CFG_DW'(cfg_r.greedy_only);
      default:           prdata = '0;
    endcase
  end

endmodule

// ----- src/qltu_qmem.sv -----
// Q-table storage: one write port and one read port, registered read data.
// Depends on qltu_pkg for the entry width.
module qltu_qmem
  import qltu_pkg::*;
#(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  logic signed [Q_W-1:0] wr_data,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output logic signed [Q_W-1:0] rd_data
);

  logic signed [Q_W-1:0] mem_r [DEPTH];
  logic signed [Q_W-1:0] rd_data_r;

  // Write and read one entry each per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- src/qltu_upd_alu.sv -----
// Pipelined update arithmetic: new = old + lr * (reward + gamma * nmax - old).
// Depends on qltu_pkg for widths and the pipeline latency.
module qltu_upd_alu
  import qltu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [LR_W-1:0]       lr,
  input  logic [LR_W-1:0]       gamma,
  input  logic signed [Q_W-1:0] old_val,
  input  logic signed [Q_W-1:0] nmax,
  input  logic signed [Q_W-1:0] reward,
  output logic                  done,
  output logic signed [Q_W-1:0] result
);

  logic [ALU_LAT-1:0]    vld_r;
  logic signed [49:0]    prod_g_r;
  logic signed [Q_W-1:0] old_s_r;
  logic signed [Q_W-1:0] reward_s_r;
  logic signed [33:0]    t_r;
  logic signed [34:0]    diff_r;
  logic [34:0]           plo_r;
  logic signed [34:0]    phi_r;
  logic signed [52:0]    p_r;
  logic signed [37:0]    sum;
  logic signed [Q_W-1:0] result_r;

  // Track the request through the stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[ALU_LAT-2:0], start};
    end
  end

  // Capture operands and the discount product
  always_ff @(posedge clk) begin
    if (start) begin
      prod_g_r   <= $signed({1'b0, gamma}) * nmax;
      old_s_r    <= old_val;
      reward_s_r <= reward;
    end
  end

  // Target, error term, split learning-rate product, recombine
  always_ff @(posedge clk) begin
    t_r    <= 34'(reward_s_r) + 34'(prod_g_r >>> 16);
    diff_r <= 35'(t_r) - 35'(old_s_r);
    plo_r  <= 35'(lr) * 35'(diff_r[17:0]);
    phi_r  <= $signed({1'b0, lr}) * $signed(diff_r[34:18]);
    p_r    <= (53'(phi_r) <<< 18) + $signed({18'b0, plo_r});
  end

  // Add the floored step to the old value and saturate
  assign sum = 38'(old_s_r) + 38'(p_r >>> 16);

  always_ff @(posedge clk) begin
    if (sum > 38'sd2147483647) begin
      result_r <= 32'sh7FFFFFFF;
    end else if (sum < -38'sd2147483648) begin
      result_r <= 32'sh80000000;
    end else begin
      result_r <= sum[Q_W-1:0];
    end
  end

  assign done   = vld_r[ALU_LAT-1];
  assign result = result_r;

endmodule

// ----- src/q_learning_table_update_top.sv -----
// Top level of the Q-table update block: request sequencer, row scan, output register.
// Depends on qltu_pkg, qltu_cfg_regs, qltu_qmem, qltu_upd_alu and the assertion header.
//
//   channel   ports                          payload      direction
//   in        in_valid, in_stall, in_data    qltu_in_t    request into the block
//   out       out_valid, out_stall, out_data qltu_out_t   one result per request
//   cfg       psel..pready (APB)             32-bit regs  register writes and reads
//
// A choose request that explores skips the row scan; a greedy choose scans the row of its state.
// In an update the single memory read port scans the next row one entry a cycle, then the
// old entry is read, passed through the 6-stage arithmetic pipeline and written back.
// After reset the table, min(NUM_STATES, 256) * NUM_ACTIONS entries (2048 by default),
// is cleared one entry a cycle while in_stall stays high.
// A finished result waits in the sequencer only while the output register is full and
// out_stall is high; the next request is taken as soon as the sequencer is free.
`include "q_learning_table_update_top_assert.svh"
module q_learning_table_update_top
  import qltu_pkg::*;
#(
  parameter int NUM_STATES  = 256,
  parameter int NUM_ACTIONS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  qltu_in_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output qltu_out_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int ROWS  = (NUM_STATES < STATE_SPAN) ? NUM_STATES : STATE_SPAN;
  localparam int RW    = $clog2(ROWS);
  localparam int AW    = $clog2(NUM_ACTIONS);
  localparam int DEPTH = ROWS * NUM_ACTIONS;
  localparam int MAW   = $clog2(DEPTH);

  // Reduce a state index modulo NUM_STATES by shifted compare and subtract
  function automatic logic [RW-1:0] red_state(input logic [STATE_W-1:0] s);
    logic [31:0] x;
    x = 32'(s);
    for (int k = STATE_W - 1; k >= 0; k--) begin
      if (x >= (32'(NUM_STATES) << k)) begin
        x = x - (32'(NUM_STATES) << k);
      end
    end
    return RW'(x);
  endfunction

  // Reduce an action index modulo NUM_ACTIONS
  function automatic logic [AW-1:0] red_action(input logic [ACT_W-1:0] a);
    logic [31:0] x;
    x = 32'(a);
    for (int k = ACT_W - 1; k >= 0; k--) begin
      if (x >= (32'(NUM_ACTIONS) << k)) begin
        x = x - (32'(NUM_ACTIONS) << k);
      end
    end
    return AW'(x);
  endfunction

  // Flat table address of one entry
  function automatic logic [MAW-1:0] ent_addr(input logic [RW-1:0] row,
                                              input logic [AW-1:0] col);
    return MAW'(MAW'(row) * MAW'(NUM_ACTIONS) + MAW'(col));
  endfunction

  qltu_cfg_t             cfg;
  qltu_state_t           state_r, state_nxt;

  logic                  req_r;
  logic [RW-1:0]         cur_row_r;
  logic [RW-1:0]         nxt_row_r;
  logic [AW-1:0]         col_r;
  logic [EPOCH_W-1:0]    epoch_r;
  logic [DRAW_W-1:0]     draw_r;
  logic [ACT_W-1:0]      ract_r;
  logic signed [Q_W-1:0] reward_r;
  logic                  explore_r;
  logic                  explore_c;
  logic [26:0]           de_prod;

  logic [AW-1:0]         scan_cnt_r;
  logic                  scan_pend_r;
  logic [AW-1:0]         scan_col_r;
  logic signed [Q_W-1:0] best_val_r;
  logic [AW-1:0]         best_idx_r;
  logic [RW-1:0]         scan_row;
  logic [MAW-1:0]        clr_cnt_r;

  logic                  rd_en, wr_en;
  logic [MAW-1:0]        rd_addr, wr_addr;
  logic signed [Q_W-1:0] rd_data, wr_data;
  logic                  alu_start, alu_done;
  logic signed [Q_W-1:0] alu_result;
  logic                  out_load;
  logic                  out_valid_r;
  qltu_out_t             out_data_r;

  qltu_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  qltu_qmem #(
    .DEPTH (DEPTH),
    .AW    (MAW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  qltu_upd_alu u_alu (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (alu_start),
    .lr      (cfg.learning_rate),
    .gamma   (cfg.discount),
    .old_val (rd_data),
    .nmax    (best_val_r),
    .reward  (reward_r),
    .done    (alu_done),
    .result  (alu_result)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign scan_row  = (req_r == REQ_UPDATE) ? nxt_row_r : cur_row_r;

  // Exploration test on the held request
  assign de_prod   = 27'(draw_r) * 27'(epoch_r);
  assign explore_c = !cfg.greedy_only &&
                     ((epoch_r == '0) || (de_prod <= 27'(cfg.explore_scale)) ||
                      (draw_r <= cfg.explore_floor_percent));

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and memory/ALU controls
  always_comb begin
    state_nxt = state_r;
    rd_en     = 1'b0;
    rd_addr   = ent_addr(scan_row, scan_cnt_r);
    wr_en     = 1'b0;
    wr_addr   = ent_addr(cur_row_r, col_r);
    wr_data   = alu_result;
    alu_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt_r;
        wr_data = '0;
        if (clr_cnt_r == MAW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        if (req_r == REQ_CHOOSE && explore_c) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_en = 1'b1;
        if (scan_cnt_r == AW'(NUM_ACTIONS - 1)) begin
          state_nxt = ST_SDRAIN;
        end
      end
      ST_SDRAIN: begin
        if (req_r == REQ_UPDATE) begin
          rd_en     = 1'b1;
          rd_addr   = ent_addr(cur_row_r, col_r);
          state_nxt = ST_OLDW;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_OLDW: begin
        alu_start = 1'b1;
        state_nxt = ST_ALU;
      end
      ST_ALU: begin
        if (alu_done) begin
          state_nxt = ST_WR;
        end
      end
      ST_WR: begin
        wr_en     = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Advance the clear pointer and the scan pipeline flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      scan_pend_r <= 1'b0;
    end else begin
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + MAW'(1);
      end
      scan_pend_r <= (state_r == ST_SCAN);
    end
  end

  // Hold the request, run the scan counter and the row maximum
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      req_r      <= in_data.req_type;
      cur_row_r  <= red_state(in_data.cur_state);
      nxt_row_r  <= red_state(in_data.next_state);
      col_r      <= red_action(in_data.taken_action);
      epoch_r    <= in_data.epoch;
      draw_r     <= in_data.random_draw;
      ract_r     <= in_data.random_action;
      reward_r   <= in_data.reward;
    end
    if (state_r == ST_CHK) begin
      explore_r <= (req_r == REQ_CHOOSE) && explore_c;
    end
    if (state_r == ST_SCAN) begin
      scan_cnt_r <= scan_cnt_r + AW'(1);
    end else if (state_r == ST_IDLE) begin
      scan_cnt_r <= '0;
    end
    scan_col_r <= scan_cnt_r;
    // Strict compare keeps the lowest index on ties
    if (scan_pend_r && (scan_col_r == '0 || rd_data > best_val_r)) begin
      best_val_r <= rd_data;
      best_idx_r <= scan_col_r;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (req_r == REQ_UPDATE) begin
        out_data_r.chosen_action <= '0;
        out_data_r.explored      <= 1'b0;
        out_data_r.new_value     <= alu_result;
      end else begin
        out_data_r.chosen_action <= explore_r ? ract_r : ACT_W'(best_idx_r);
        out_data_r.explored      <= explore_r;
        out_data_r.new_value     <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `QLTU_ASSERT(a_alu_latency, clk, rst_n, alu_start |-> ##ALU_LAT alu_done)
  `QLTU_ASSERT(a_out_from_fin, clk, rst_n, $rose(out_valid_r) |-> $past(state_r == ST_FIN))
  `QLTU_ASSERT(a_upd_no_action, clk, rst_n, (out_valid_r && out_data_r.new_value != '0) |-> (out_data_r.explored == 1'b0 && out_data_r.chosen_action == '0))
  `QLTU_ASSERT_NEVER(a_scan_range, clk, rst_n, state_r == ST_SCAN && scan_cnt_r > AW'(NUM_ACTIONS - 1))

endmodule

// ----- tb/q_learning_table_update_top_test.sv -----
// Testbench for q_learning_table_update_top: choose and update requests checked against
// a mirrored Q table and register set, plus APB register write and read-back checks.
// Depends on qltu_pkg and the block's RTL; needs no other files.
`timescale 1ns / 100ps

module q_learning_table_update_top_test;
  import qltu_pkg::*;

  localparam int N_ROWS = 256;
  localparam int N_COLS = 8;
  localparam logic [2:0] REG_UNMAPPED = 3'd5;
  localparam longint Q_MAX = 64'sh7FFF_FFFF;
  localparam longint Q_MIN = -64'sh8000_0000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  qltu_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  qltu_out_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  // Mirrored block state and the results still owed
  int q_mirror [N_ROWS*N_COLS];
  qltu_cfg_t cfg_mirror;
  qltu_out_t pending_results [$];
  int err_count = 0;
  bit idle_on = 1'b1;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  q_learning_table_update_top #(
    .NUM_STATES (N_ROWS),
    .NUM_ACTIONS(N_COLS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("%s", msg);
  endtask

  // Greedy column of a mirrored row, lowest index on ties
  function automatic int best_action(input logic [STATE_W-1:0] row);
    int best;
    best = 0;
    for (int a = 1; a < N_COLS; a++)
      if (q_mirror[row*N_COLS + a] > q_mirror[row*N_COLS + best]) best = a;
    return best;
  endfunction

  // Work out the result of one request and apply its table write
  function automatic qltu_out_t predict_result(input qltu_in_t r);
    qltu_out_t res;
    int unsigned reach;
    bit explore;
    int slot;
    longint old_v, next_max, target, delta, upd;
    res = '0;
    if (r.req_type == REQ_CHOOSE) begin
      reach = r.random_draw * r.epoch;
      explore = !cfg_mirror.greedy_only &&
                (r.epoch == 0 || reach <= cfg_mirror.explore_scale ||
                 r.random_draw <= cfg_mirror.explore_floor_percent);
      res.chosen_action = explore ? r.random_action : ACT_W'(best_action(r.cur_state));
      res.explored = explore;
    end else begin
      slot = r.cur_state * N_COLS + r.taken_action;
      old_v = q_mirror[slot];
      next_max = q_mirror[r.next_state * N_COLS + best_action(r.next_state)];
      target = longint'($signed(r.reward)) +
               ((longint'(cfg_mirror.discount) * next_max) >>> 16);
      delta = (longint'(cfg_mirror.learning_rate) * (target - old_v)) >>> 16;
      upd = old_v + delta;
      if (upd > Q_MAX) upd = Q_MAX;
      if (upd < Q_MIN) upd = Q_MIN;
      q_mirror[slot] = int'(upd);
      res.new_value = upd[31:0];
    end
    return res;
  endfunction

  // Offer one request, optionally after an idle burst, and log its expected result
  task automatic send_req(input qltu_in_t r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_data <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_result(r));
  endtask

  // Drop valid and wait until every owed result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // APB write (optional) followed by a read-back check of the register; an unmapped write gets no read-back
  task automatic reg_access(input logic [2:0] idx, input bit wr, input logic [31:0] val);
    logic [31:0] want;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    if (wr) begin
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      case (idx)
        REG_LEARNING_RATE: cfg_mirror.learning_rate = val[LR_W-1:0];
        REG_DISCOUNT:      cfg_mirror.discount = val[LR_W-1:0];
        REG_EXPLORE_SCALE: cfg_mirror.explore_scale = val[SCALE_W-1:0];
        REG_EXPLORE_FLOOR: cfg_mirror.explore_floor_percent = val[FLOOR_W-1:0];
        REG_GREEDY_ONLY:   cfg_mirror.greedy_only = val[0];
        default: ;
      endcase
      if (idx > REG_GREEDY_ONLY) begin
        psel <= 1'b0;
        penable <= 1'b0;
        return;
      end
      pwrite <= 1'b0;
      penable <= 1'b0;
    end
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_LEARNING_RATE: want = 32'(cfg_mirror.learning_rate);
      REG_DISCOUNT:      want = 32'(cfg_mirror.discount);
      REG_EXPLORE_SCALE: want = 32'(cfg_mirror.explore_scale);
      REG_EXPLORE_FLOOR: want = 32'(cfg_mirror.explore_floor_percent);
      default:           want = 32'(cfg_mirror.greedy_only);
    endcase
    if (prdata !== want)
      flag_error($sformatf("register %0d read 0x%08h, expected 0x%08h", idx, prdata, want));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Reprogram all registers once the block has gone idle
  task automatic apply_config(input logic [31:0] lr, input logic [31:0] disc,
                              input logic [31:0] scale, input logic [31:0] floor_pct,
                              input logic [31:0] greedy);
    drain_results();
    reg_access(REG_LEARNING_RATE, 1'b1, lr);
    reg_access(REG_DISCOUNT, 1'b1, disc);
    reg_access(REG_EXPLORE_SCALE, 1'b1, scale);
    reg_access(REG_EXPLORE_FLOOR, 1'b1, floor_pct);
    reg_access(REG_GREEDY_ONLY, 1'b1, greedy);
  endtask

  function automatic qltu_in_t mk_req(input logic kind, input logic [STATE_W-1:0] cur,
                                      input logic [EPOCH_W-1:0] ep,
                                      input logic [DRAW_W-1:0] draw,
                                      input logic [ACT_W-1:0] ract,
                                      input logic [ACT_W-1:0] tact,
                                      input logic signed [Q_W-1:0] rwd,
                                      input logic [STATE_W-1:0] nxt);
    qltu_in_t r;
    r.req_type = kind;
    r.cur_state = cur;
    r.epoch = ep;
    r.random_draw = draw;
    r.random_action = ract;
    r.taken_action = tact;
    r.reward = rwd;
    r.next_state = nxt;
    return r;
  endfunction

  // Mostly a few hot rows at both ends, so updates pile up and greedy reads see them
  function automatic logic [STATE_W-1:0] pick_state();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return STATE_W'($urandom_range(0, 5));
      6, 7:             return STATE_W'($urandom_range(250, 255));
      default:          return STATE_W'($urandom);
    endcase
  endfunction

  function automatic qltu_in_t random_req();
    qltu_in_t r;
    r.req_type = 1'($urandom_range(0, 1));
    r.cur_state = pick_state();
    r.next_state = pick_state();
    case ($urandom_range(0, 5))
      0:       r.epoch = '0;
      1:       r.epoch = '1;
      2:       r.epoch = EPOCH_W'($urandom_range(1, 300));
      default: r.epoch = EPOCH_W'($urandom);
    endcase
    r.random_draw = ($urandom_range(0, 4) == 0) ? DRAW_W'($urandom)
                                                : DRAW_W'($urandom_range(0, 99));
    r.random_action = ACT_W'($urandom);
    r.taken_action = ACT_W'($urandom);
    case ($urandom_range(0, 7))
      0:       r.reward = 32'sh7FFF_FFFF;
      1:       r.reward = 32'sh8000_0000;
      2, 3:    r.reward = $urandom;
      default: r.reward = $urandom_range(0, 32'h0014_0000) - 32'h000A_0000;
    endcase
    return r;
  endfunction

  // Reset values, then a write to an unmapped address that must change nothing
  task automatic test_register_file();
    for (int i = 0; i <= 4; i++) reg_access(3'(i), 1'b0, '0);
    reg_access(REG_UNMAPPED, 1'b1, 32'hFFFF_FFFF);
    for (int i = 0; i <= 4; i++) reg_access(3'(i), 1'b0, '0);
  endtask

  task automatic test_corner_requests();
    // exploration bounds on an all-zero table
    send_req(mk_req(REQ_CHOOSE, 8'd0, 20'd0, 7'd127, 3'd7, 3'd0, 0, 8'd0));
    send_req(mk_req(REQ_CHOOSE, 8'd0, 20'hFFFFF, 7'd99, 3'd2, 3'd7, 0, 8'd255));
    send_req(mk_req(REQ_CHOOSE, 8'd17, 20'd125, 7'd100, 3'd5, 3'd0, 0, 8'd0));
    send_req(mk_req(REQ_CHOOSE, 8'd17, 20'd126, 7'd100, 3'd5, 3'd0, 0, 8'd0));
    send_req(mk_req(REQ_CHOOSE, 8'd9, 20'd100000, 7'd10, 3'd3, 3'd0, 0, 8'd0));
    send_req(mk_req(REQ_CHOOSE, 8'd9, 20'd100000, 7'd11, 3'd3, 3'd0, 0, 8'd0));
    // updates at the row and column extremes, the second with next row equal to own row
    send_req(mk_req(REQ_UPDATE, 8'd255, 20'd0, 7'd0, 3'd0, 3'd7, 32'sh7FFF_FFFF, 8'd0));
    send_req(mk_req(REQ_UPDATE, 8'd255, 20'd0, 7'd0, 3'd0, 3'd3, 32'sh8000_0000, 8'd255));
    send_req(mk_req(REQ_CHOOSE, 8'd255, 20'hFFFFF, 7'd127, 3'd1, 3'd0, 0, 8'd0));
    // factors above 1.0 push past the 32-bit range; greedy mode overrides epoch zero
    apply_config(32'h1FFFF, 32'h1FFFF, 32'(SCALE_RESET), 32'(FLOOR_RESET), 32'd1);
    send_req(mk_req(REQ_UPDATE, 8'd1, 20'd0, 7'd0, 3'd0, 3'd0, 32'sh7FFF_FFFF, 8'd255));
    send_req(mk_req(REQ_UPDATE, 8'd1, 20'd0, 7'd0, 3'd0, 3'd7, 32'sh8000_0000, 8'd2));
    send_req(mk_req(REQ_UPDATE, 8'd2, 20'd0, 7'd0, 3'd0, 3'd4, 32'sd1, 8'd2));
    send_req(mk_req(REQ_UPDATE, 8'd3, 20'd0, 7'd0, 3'd0, 3'd2, 32'sd5, 8'd9));
    send_req(mk_req(REQ_UPDATE, 8'd3, 20'd0, 7'd0, 3'd0, 3'd6, 32'sd5, 8'd9));
    send_req(mk_req(REQ_UPDATE, 8'd5, 20'd0, 7'd0, 3'd0, 3'd1, 32'sd7, 8'd1));
    send_req(mk_req(REQ_CHOOSE, 8'd1, 20'd0, 7'd0, 3'd6, 3'd0, 0, 8'd0));
    send_req(mk_req(REQ_CHOOSE, 8'd2, 20'd0, 7'd0, 3'd6, 3'd0, 0, 8'd0));
    send_req(mk_req(REQ_CHOOSE, 8'd3, 20'd0, 7'd0, 3'd6, 3'd0, 0, 8'd0));
  endtask

  // Random traffic under a sequence of register settings; phase 3 and the last phase run without gaps
  task automatic test_random_phases();
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: apply_config(32'd6554, 32'd39322, 32'd12500, 32'd10, 32'd0);
        1: apply_config(32'd65536, 32'd65536, 32'd0, 32'd0, 32'd0);
        2: apply_config(32'h1FFFF, 32'h1FFFF, 32'hFF_FFFF, 32'd127, 32'd0);
        3: apply_config(32'd0, 32'd0, $urandom, $urandom_range(0, 127), 32'd1);
        4: apply_config($urandom, $urandom, $urandom, $urandom, $urandom);
        default: apply_config(32'd32768, 32'd58982, 32'd500, 32'd5, 32'd0);
      endcase
      idle_on = (ph != 3 && ph != 5);
      repeat (85) send_req(random_req());
    end
  endtask

  // Random stall bursts on the result side
  initial begin : result_stall
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_results
    qltu_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        flag_error($sformatf("unexpected result: action %0d explored %0b value 0x%08h",
                             out_data.chosen_action, out_data.explored, out_data.new_value));
      end else begin
        want = pending_results.pop_front();
        if (out_data.chosen_action !== want.chosen_action ||
            out_data.explored !== want.explored || out_data.new_value !== want.new_value)
          flag_error($sformatf({"result mismatch: expected action %0d explored %0b ",
                                "value 0x%08h, got action %0d explored %0b value 0x%08h"},
                               want.chosen_action, want.explored, want.new_value,
                               out_data.chosen_action, out_data.explored,
                               out_data.new_value));
      end
    end
  end

  initial begin : run_tests
    cfg_mirror.learning_rate = LR_RESET;
    cfg_mirror.discount = DISC_RESET;
    cfg_mirror.explore_scale = SCALE_RESET;
    cfg_mirror.explore_floor_percent = FLOOR_RESET;
    cfg_mirror.greedy_only = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_register_file();
    test_corner_requests();
    test_random_phases();
    drain_results();
    repeat (40) @(posedge clk);
    if (err_count == 0) begin
      $display("q_learning_table_update_top_test: done, clean");
    end else begin
      $display("q_learning_table_update_top_test: done, errors");
    end
    $finish;
  end

  // Hard stop well beyond the slowest passing run
  initial begin : watchdog
    #3_000_000;
    $display("q_learning_table_update_top_test: done, errors");
    $finish;
  end

endmodule
